FILE: rtl/ajq_pkg.sv
// ----------------------------------------------------------------------------
// ajq_pkg
// shared types and constants of the job queue with owner affinity
// ----------------------------------------------------------------------------
package ajq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP        = 3'd2,
        ACT_ERASE      = 3'd3,
        ACT_COUNT      = 3'd4
    } action_t;

    typedef struct packed {
        logic [7:0]  job_type;
        logic [31:0] handle;
        logic [15:0] owner;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MOVE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;         // capture request beat
        logic rd_en;        // read entry at rd_ptr
        logic wr_new;       // write captured entry at wr_ptr
        logic wr_copy;      // write read entry at wr_ptr
        logic rd_inc;
        logic wr_inc;
        logic rd_dec;
        logic wr_dec;
        logic start_back;   // wr_ptr = count
        logic start_front;  // rd_ptr = count-1, wr_ptr = count
        logic start_scan;   // rd_ptr = 0, wr_ptr = 0
        logic take;         // latch read entry as result
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_set_wr;   // count = wr_ptr
        logic set_rej;
        logic out_load;
    } ajq_cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    rd_at_end;   // rd_ptr reached count
        logic    rd_at_zero;
        logic    match_owner;
        logic    match_type;
        logic    taken;
    } ajq_stat_t;

endpackage

FILE: rtl/affinity_job_queue_top.sv
// ----------------------------------------------------------------------------
// affinity_job_queue_top
// bounded double-ended job queue with owner affinity
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. Entries live in a 16-deep memory
// with the head at index 0. Push back writes the new entry at the tail; count,
// the unused action codes and a rejected push only load the result. Pop, erase
// and push front walk the single-port entry memory one entry at a time (read,
// then move). A result still waiting in the output register holds the next
// one until the old beat is collected. Pop removes the first entry whose owner
// is 0 or the requester and closes the gap; erase drops all entries of a type.
// A push to a full queue is dropped and flagged by rejected. The next request
// is taken once the result is in the output register, even if not yet
// collected.
// ----------------------------------------------------------------------------
module affinity_job_queue_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  new_type,
    input  logic [31:0] new_handle,
    input  logic [15:0] new_owner,
    input  logic [15:0] requester_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        got_job,
    output logic [7:0]  out_type,
    output logic [31:0] out_handle,
    output logic [15:0] out_owner,
    output logic [4:0]  queue_count,
    output logic        rejected
);
    import ajq_pkg::*;

    ajq_cmd_t  cmd;   // sequencer commands
    ajq_stat_t stat;  // datapath status

    ajq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ajq_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .new_type     (new_type),
        .new_handle   (new_handle),
        .new_owner    (new_owner),
        .requester_id (requester_id),
        .got_job      (got_job),
        .out_type     (out_type),
        .out_handle   (out_handle),
        .out_owner    (out_owner),
        .queue_count  (queue_count),
        .rejected     (rejected)
    );

endmodule

FILE: rtl/ajq_datapath.sv
// ----------------------------------------------------------------------------
// ajq_datapath
// entry memory, pointers, occupancy and result register
// ----------------------------------------------------------------------------
module ajq_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  ajq_pkg::ajq_cmd_t cmd,
    output ajq_pkg::ajq_stat_t stat,
    input  logic [2:0]        action,
    input  logic [7:0]        new_type,
    input  logic [31:0]       new_handle,
    input  logic [15:0]       new_owner,
    input  logic [15:0]       requester_id,
    output logic              got_job,
    output logic [7:0]        out_type,
    output logic [31:0]       out_handle,
    output logic [15:0]       out_owner,
    output logic [4:0]        queue_count,
    output logic              rejected
);
    import ajq_pkg::*;

    entry_t            mem [QUEUE_DEPTH];
    entry_t            rd_data_reg;
    entry_t            new_reg;
    entry_t            res_reg;
    logic [2:0]        act_reg;
    logic [15:0]       req_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  wr_ptr_reg;
    logic              taken_reg;
    logic              rej_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        if (cmd.wr_new)
            mem[wr_ptr_reg[IDX_W-1:0]] <= new_reg;
        else if (cmd.wr_copy)
            mem[wr_ptr_reg[IDX_W-1:0]] <= rd_data_reg;
        if (cmd.load)
        begin
            new_reg <= '{job_type: new_type, handle: new_handle, owner: new_owner};
            act_reg <= action;
            req_reg <= requester_id;
        end
        if (cmd.take)
            res_reg <= rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            taken_reg  <= 1'b0;
            rej_reg    <= 1'b0;
            got_job    <= 1'b0;
            out_type   <= '0;
            out_handle <= '0;
            out_owner  <= '0;
            queue_count <= '0;
            rejected   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                taken_reg <= 1'b0;
                rej_reg   <= 1'b0;
            end
            if (cmd.take)
                taken_reg <= 1'b1;
            if (cmd.set_rej)
                rej_reg <= 1'b1;
            if (cmd.start_back)
                wr_ptr_reg <= cnt_reg;
            else if (cmd.start_front)
            begin
                rd_ptr_reg <= cnt_reg - 1'b1;
                wr_ptr_reg <= cnt_reg;
            end
            else if (cmd.start_scan)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
            end
            else
            begin
                if (cmd.rd_inc)
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                else if (cmd.rd_dec)
                    rd_ptr_reg <= rd_ptr_reg - 1'b1;
                if (cmd.wr_inc)
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                else if (cmd.wr_dec)
                    wr_ptr_reg <= wr_ptr_reg - 1'b1;
            end
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - 1'b1;
            else if (cmd.cnt_set_wr)
                cnt_reg <= wr_ptr_reg;
            if (cmd.out_load)
            begin
                got_job     <= taken_reg;
                out_type    <= taken_reg ? res_reg.job_type : '0;
                out_handle  <= taken_reg ? res_reg.handle : '0;
                out_owner   <= taken_reg ? res_reg.owner : '0;
                queue_count <= 5'(cnt_reg);
                rejected    <= rej_reg;
            end
        end
    end

    always_comb
    begin
        stat.action      = action_t'(act_reg);
        stat.full        = (cnt_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty       = (cnt_reg == '0);
        stat.rd_at_end   = (rd_ptr_reg == cnt_reg);
        stat.rd_at_zero  = (rd_ptr_reg == '0);
        stat.match_owner = (rd_data_reg.owner == '0) || (rd_data_reg.owner == req_reg);
        stat.match_type  = (rd_data_reg.job_type == new_reg.job_type);
        stat.taken       = taken_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !stat.empty)
        else $error("remove from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_copy |-> wr_ptr_reg <= rd_ptr_reg + 1'b1)
        else $error("compaction writer ahead of reader");

endmodule

FILE: rtl/ajq_ctrl.sv
// ----------------------------------------------------------------------------
// ajq_ctrl
// sequencer for push, pop scan, erase compaction and count
// ----------------------------------------------------------------------------
module ajq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ajq_pkg::ajq_stat_t stat,
    output ajq_pkg::ajq_cmd_t  cmd
);
    import ajq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   busy_reg;
    logic   busy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
        end
    end

    assign out_valid = out_valid_reg;
    // a new beat may enter while the previous result still waits
    assign in_ready  = !busy_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        busy_next      = busy_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    busy_next  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                unique case (stat.action)
                    ACT_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_rej = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.start_back = 1'b1;
                            state_next     = ST_WRITE;
                        end
                    end
                    ACT_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_rej = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.start_front = 1'b1;
                            state_next      = ST_MOVE;
                        end
                    end
                    ACT_POP, ACT_ERASE:
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_MOVE;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_MOVE:
            begin
                // issue read at rd_ptr, or finish
                if (stat.action == ACT_PUSH_FRONT)
                begin
                    if (stat.rd_at_end || stat.empty ||
                        (stat.rd_at_zero && 1'b0))
                        state_next = ST_WRITE;
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
                else if (stat.rd_at_end)
                begin
                    if (stat.action == ACT_ERASE || stat.taken)
                        cmd.cnt_set_wr = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.action == ACT_PUSH_FRONT)
                begin
                    cmd.wr_copy = 1'b1;
                    cmd.wr_dec  = 1'b1;
                    if (stat.rd_at_zero)
                        state_next = ST_WRITE;
                    else
                    begin
                        cmd.rd_dec = 1'b1;
                        state_next = ST_MOVE;
                    end
                end
                else if (stat.action == ACT_POP)
                begin
                    cmd.rd_inc = 1'b1;
                    state_next = ST_MOVE;
                    if (!stat.taken && stat.match_owner)
                        cmd.take = 1'b1;
                    else
                    begin
                        cmd.wr_copy = 1'b1;
                        cmd.wr_inc  = 1'b1;
                    end
                end
                else
                begin
                    cmd.rd_inc = 1'b1;
                    state_next = ST_MOVE;
                    if (!stat.match_type)
                    begin
                        cmd.wr_copy = 1'b1;
                        cmd.wr_inc  = 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    busy_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("beat taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !stat.taken)
        else $error("second job taken in one pop");

endmodule

FILE: bench/affinity_job_queue_top_tb.sv
// ----------------------------------------------------------------------------
// affinity_job_queue_top_tb
// self-checking bench for the job queue with owner affinity
// ----------------------------------------------------------------------------
// Drives request beats through the valid/ready input channel and checks every
// result beat against a behavioral model of the queue kept in the bench.
// Directed tests cover full and empty queues, affinity scans, erase and the
// unused action codes; random phases mix well-formed job traffic with noise
// under three idling profiles.
// ----------------------------------------------------------------------------
module affinity_job_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ajq_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic        got_job;
        logic [7:0]  out_type;
        logic [31:0] out_handle;
        logic [15:0] out_owner;
        logic [4:0]  queue_count;
        logic        rejected;
    } job_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [7:0]  new_type;
    logic [31:0] new_handle;
    logic [15:0] new_owner;
    logic [15:0] requester_id;
    logic        out_valid;
    logic        out_ready;
    logic        got_job;
    logic [7:0]  out_type;
    logic [31:0] out_handle;
    logic [15:0] out_owner;
    logic [4:0]  queue_count;
    logic        rejected;

    affinity_job_queue_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .new_type(new_type), .new_handle(new_handle),
        .new_owner(new_owner), .requester_id(requester_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .got_job(got_job), .out_type(out_type), .out_handle(out_handle),
        .out_owner(out_owner), .queue_count(queue_count), .rejected(rejected)
    );

    // shadow copy of the queue, head at index 0
    entry_t      shadow_q[$];
    job_result_t pending_results[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;   // percent of cycles the sender idles
    int          recv_idle_pct = 0;   // percent of cycles the receiver stalls
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // compute the result of one request beat and update the shadow queue
    function automatic job_result_t apply_job_request(logic [2:0] act, logic [7:0] jt,
                                                      logic [31:0] jh, logic [15:0] jo,
                                                      logic [15:0] req);
        job_result_t r;
        entry_t      e;
        entry_t      kept[$];
        r = '0;
        e.job_type = jt;
        e.handle   = jh;
        e.owner    = jo;
        if (act == ACT_PUSH_BACK || act == ACT_PUSH_FRONT)
        begin
            if (shadow_q.size() >= QUEUE_DEPTH)
                r.rejected = 1'b1;
            else if (act == ACT_PUSH_BACK)
                shadow_q.insert(shadow_q.size(), e);
            else
                shadow_q.insert(0, e);
        end
        else if (act == ACT_POP)
        begin
            for (int i = 0; i < shadow_q.size(); i++)
            begin
                if (shadow_q[i].owner == 16'd0 || shadow_q[i].owner == req)
                begin
                    r.got_job    = 1'b1;
                    r.out_type   = shadow_q[i].job_type;
                    r.out_handle = shadow_q[i].handle;
                    r.out_owner  = shadow_q[i].owner;
                    shadow_q.delete(i);
                    break;
                end
            end
        end
        else if (act == ACT_ERASE)
        begin
            foreach (shadow_q[i])
                if (shadow_q[i].job_type != jt)
                    kept.insert(kept.size(), shadow_q[i]);
            shadow_q = kept;
        end
        r.queue_count = 5'(shadow_q.size());
        return r;
    endfunction

    // one request beat; valid stays up until accepted and drops only to idle
    task automatic send_job(logic [2:0] act, logic [7:0] jt, logic [31:0] jh,
                            logic [15:0] jo, logic [15:0] req);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        new_type     <= jt;
        new_handle   <= jh;
        new_owner    <= jo;
        requester_id <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(),
                               apply_job_request(act, jt, jh, jo, req));
    endtask

    // receiver stalls and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat", $time);
                    fail_count++;
                end
                else
                begin
                    job_result_t want;
                    job_result_t seen;
                    want = pending_results[0];
                    pending_results.delete(0);
                    seen = {got_job, out_type, out_handle, out_owner, queue_count, rejected};
                    if (seen !== want)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, seen);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
            out_ready <= 1'b0;
    end

    // watchdog on cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [15:0] pick_owner();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 3));
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        // small set of types so erase actually hits entries
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    task automatic test_push_pop_extremes();
        send_job(ACT_POP, 8'd0, 32'd0, 16'd0, 16'd1);          // pop when empty
        send_job(ACT_COUNT, 8'd0, 32'd0, 16'd0, 16'd1);
        send_job(ACT_PUSH_BACK, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_job(ACT_PUSH_FRONT, 8'h00, 32'h0, 16'h0, 16'h0);
        send_job(ACT_POP, 8'd0, 32'd0, 16'd0, 16'hFFFF);
        send_job(ACT_POP, 8'd0, 32'd0, 16'd0, 16'hFFFF);
        send_job(ACT_POP, 8'd0, 32'd0, 16'd0, 16'd0);           // requester zero
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_job(ACT_PUSH_BACK, 8'(i % 3), 32'hA5A5_0000 + i, 16'(i % 2 ? 5 : 7), 16'd1);
        send_job(ACT_PUSH_BACK, 8'd9, 32'd1, 16'd0, 16'd1);     // push when full
        send_job(ACT_PUSH_FRONT, 8'd9, 32'd1, 16'd0, 16'd1);
        send_job(ACT_POP, 8'd0, 32'd0, 16'd0, 16'd9);           // no eligible entry
        send_job(ACT_POP, 8'd0, 32'd0, 16'd0, 16'd5);           // affinity past head
        send_job(3'd5, 8'd0, 32'd0, 16'd0, 16'd1);              // unused codes
        send_job(3'd6, 8'd0, 32'd0, 16'd0, 16'd1);
        send_job(3'd7, 8'd0, 32'd0, 16'd0, 16'd1);
        send_job(ACT_ERASE, 8'd1, 32'd0, 16'd0, 16'd1);
        send_job(ACT_ERASE, 8'd7, 32'd0, 16'd0, 16'd1);         // erase nothing
        send_job(ACT_ERASE, 8'd0, 32'd0, 16'd0, 16'd1);
        send_job(ACT_ERASE, 8'd2, 32'd0, 16'd0, 16'd1);         // to empty
    endtask

    task automatic test_random_traffic(int n_items, int s_idle, int r_idle);
        int pick;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_job(ACT_PUSH_BACK, pick_type(), $urandom, pick_owner(), 16'($urandom));
            else if (pick < 50)
                send_job(ACT_PUSH_FRONT, pick_type(), $urandom, pick_owner(), 16'($urandom));
            else if (pick < 80)
                send_job(ACT_POP, 8'($urandom), $urandom, 16'($urandom),
                         $urandom_range(1) ? 16'($urandom_range(0, 3)) : 16'($urandom));
            else if (pick < 88)
                send_job(ACT_ERASE, pick_type(), $urandom, 16'($urandom), 16'($urandom));
            else
                send_job(3'($urandom_range(4, 7)), 8'($urandom), $urandom,
                         16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = '0;
        new_type     = '0;
        new_handle   = '0;
        new_owner    = '0;
        requester_id = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_push_pop_extremes();
        test_full_queue();
        test_random_traffic(360, 8, 88);
        test_random_traffic(360, 88, 8);
        test_random_traffic(360, 0, 0);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: affinity_job_queue_top.f
rtl/ajq_pkg.sv
rtl/ajq_datapath.sv
rtl/ajq_ctrl.sv
rtl/affinity_job_queue_top.sv
bench/affinity_job_queue_top_tb.sv
